### rtl/dlefr_pkg.sv
// ----------------------------------------------------------------------------
// dlefr_pkg
// Shared types, link symbols and the CRC-16 byte update for the framed receiver.
// ----------------------------------------------------------------------------
package dlefr_pkg;

  localparam logic [7:0]  SYM_DLE  = 8'h10;
  localparam logic [7:0]  SYM_STX  = 8'h02;
  localparam logic [7:0]  SYM_ETX  = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [8:0]  MIN_LEN_RESET = 9'd6;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_ABORT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [8:0] frame_length;
  } result_t;

  // msb-first crc-16, one byte folded in, eight shift steps unrolled
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### rtl/dle_framed_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// dle_framed_receiver_crc16_top
// DLE STX / DLE ETX frame receiver with byte unstuffing and CRC-16 check.
// ----------------------------------------------------------------------------
// Takes one raw link byte per clock while in_stall is low and gives at most
// one registered result beat per byte: a payload byte with its index, or a
// frame end (accepted, rejected or aborted) with the unstuffed length. The
// framing state and the unrolled CRC-16 byte update are combinational, so
// the sustained rate is one byte per cycle while in_stall is low. Results
// pass through an output register backed by a one-beat skid register;
// in_stall rises only while the skid register holds a beat, i.e. after the
// output side has stalled with two results pending. min_frame_length may be
// written at any time the receiver is quiet; cfg_ready is always high.
module dle_framed_receiver_crc16_top
  import dlefr_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index,
  output logic [8:0] frame_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] min_frame_length
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam logic [CW-1:0] LAST_COUNT = CW'(MAX_FRAME - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_FRAME);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OPEN = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t        phase, phase_next;
  logic          escape_pending, escape_pending_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   crc_residue, crc_residue_next;
  logic [8:0]    min_len;

  logic          res_valid;
  result_t       res;
  result_t       out_reg, skid_reg;
  logic          skid_valid;
  logic          accept, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign out_free  = !out_valid || !out_stall;

  assign kind         = out_reg.kind;
  assign data_byte    = out_reg.data_byte;
  assign byte_index   = out_reg.byte_index;
  assign frame_length = out_reg.frame_length;

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    crc_residue_next    = crc_residue;
    res_valid           = 1'b0;
    res                 = '{KIND_DATA, 8'h00, 8'h00, 9'h000};
    unique case (phase)
      PH_OPEN: begin
        escape_pending_next = 1'b0;
        if (rx_byte == SYM_STX) begin
          phase_next       = PH_BODY;
          byte_count_next  = '0;
          crc_residue_next = '0;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_BODY: begin
        if (!escape_pending && rx_byte == SYM_DLE) begin
          escape_pending_next = 1'b1;
        end else if (escape_pending && rx_byte == SYM_ETX) begin
          escape_pending_next = 1'b0;
          phase_next          = PH_IDLE;
          res_valid           = 1'b1;
          res.frame_length    = 9'(byte_count);
          if (crc_residue == 16'h0000 &&
              {9'h000, byte_count} >= {{CW{1'b0}}, min_len}) begin
            res.kind = KIND_ACCEPT;
          end else begin
            res.kind = KIND_REJECT;
          end
        end else if (escape_pending && rx_byte != SYM_DLE) begin
          escape_pending_next = 1'b0;
          phase_next          = PH_IDLE;
          res_valid           = 1'b1;
          res.kind            = KIND_ABORT;
          res.frame_length    = 9'(byte_count);
        end else if (byte_count >= LAST_COUNT) begin
          // data byte that would fill the frame ends it instead
          escape_pending_next = 1'b0;
          phase_next          = PH_IDLE;
          byte_count_next     = FULL_COUNT;
          res_valid           = 1'b1;
          res.kind            = KIND_ABORT;
          res.frame_length    = 9'(FULL_COUNT);
        end else begin
          escape_pending_next = 1'b0;
          crc_residue_next    = crc_fold(crc_residue, rx_byte);
          byte_count_next     = byte_count + 1'b1;
          res_valid           = 1'b1;
          res.kind            = KIND_DATA;
          res.data_byte       = rx_byte;
          res.byte_index      = 8'(byte_count);
        end
      end
      default: begin
        escape_pending_next = 1'b0;
        phase_next          = (rx_byte == SYM_DLE) ? PH_OPEN : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      crc_residue    <= '0;
      min_len        <= MIN_LEN_RESET;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_len <= min_frame_length;
      end
      if (accept) begin
        phase          <= phase_next;
        escape_pending <= escape_pending_next;
        byte_count     <= byte_count_next;
        crc_residue    <= crc_residue_next;
      end
      if (skid_valid) begin
        if (out_free) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (out_free) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat held with empty output register");

  a_data_no_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind == KIND_DATA) |-> (out_reg.frame_length == 9'h000))
    else $error("payload beat carries a frame length");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind != KIND_DATA) |->
      (out_reg.data_byte == 8'h00 && out_reg.byte_index == 8'h00))
    else $error("frame end beat carries payload");

  a_escape_in_body: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> (phase == PH_BODY))
    else $error("escape pending outside a frame");
`endif

endmodule
